[rtl/tte_pkg.sv]
// Shared types, codes and helpers for the text terminal escape engine.
package tte_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] PS_IDLE = 2'd0;
  localparam logic [1:0] PS_ESC  = 2'd1;
  localparam logic [1:0] PS_CSI  = 2'd2;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP    = 8'h41;
  localparam logic [7:0] CH_DOWN  = 8'h42;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT  = 8'h44;
  localparam logic [7:0] CH_POS_H = 8'h48;
  localparam logic [7:0] CH_POS_F = 8'h66;
  localparam logic [7:0] CH_ED    = 8'h4A;
  localparam logic [7:0] CH_EL    = 8'h4B;
  localparam logic [7:0] CH_SGR   = 8'h6D;
  localparam logic [7:0] CH_SAVE  = 8'h73;
  localparam logic [7:0] CH_REST  = 8'h75;

  localparam int NUM_W = 14;
  localparam logic [NUM_W-1:0] NUM_LIMIT = 14'd9999;

  localparam logic [NUM_W-1:0] SGR_RESET = 14'd0;
  localparam logic [NUM_W-1:0] SGR_FG_LO = 14'd30;
  localparam logic [NUM_W-1:0] SGR_FG_HI = 14'd37;
  localparam logic [NUM_W-1:0] SGR_BG_LO = 14'd40;
  localparam logic [NUM_W-1:0] SGR_BG_HI = 14'd47;

  localparam logic [2:0] FG_DEFAULT = 3'd7;
  localparam logic [2:0] BG_DEFAULT = 3'd0;

  typedef logic [15:0] cell_t;

  function automatic cell_t pack_cell(logic [7:0] ch, logic [2:0] fg, logic [2:0] bg);
    pack_cell = {1'b0, bg, 1'b0, fg, ch};
  endfunction

  localparam cell_t BLANK_RESET = {1'b0, BG_DEFAULT, 1'b0, FG_DEFAULT, CH_SPACE};

endpackage

[rtl/tte_if.sv]
// Item and result channels of the text terminal escape engine.
interface tte_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] terminal_id;
  logic [7:0] byte_in;
  logic [4:0] cell_row;
  logic [6:0] cell_col;
  modport source (output valid, opcode, terminal_id, byte_in, cell_row, cell_col,
                  input ready);
  modport sink (input valid, opcode, terminal_id, byte_in, cell_row, cell_col,
                output ready);
endinterface

interface tte_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  logic [4:0]  cur_row;
  logic [6:0]  cur_col;
  logic [2:0]  current_fg;
  logic [2:0]  current_bg;
  modport source (output valid, cell_value, cur_row, cur_col, current_fg,
                  current_bg, input ready);
  modport sink (input valid, cell_value, cur_row, cur_col, current_fg,
                current_bg, output ready);
endinterface

[rtl/tte_cell_mem.sv]
// Screen cell store: one write port, one registered read port.
module tte_cell_mem #(
  parameter int DEPTH = 8000,
  parameter int AW    = 13
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  tte_pkg::cell_t    wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output tte_pkg::cell_t    rdata_o
);

  tte_pkg::cell_t mem [DEPTH];
  tte_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/text_terminal_escape_engine.sv]
// Text terminal escape engine top level.
// Several character-cell terminals share one cell store; each item writes a byte through
// an ANSI ESC [ parser, reads one cell, clears a terminal or, for opcode 3, does nothing,
// and returns one result with the cursor and colours. One item is in flight at a time.
// K, J and tab blank one cell at a time, m applies its parameters one by one, a scroll
// copies each cell of the lower rows up a line and then blanks the new line, and a full
// clear blanks every cell of the terminal, all through the single write port of the
// cell store. The next item is taken only after the result is accepted. After reset the
// store is swept to blanks before the first item is taken.
module text_terminal_escape_engine #(
  parameter int TERMINALS   = 4,
  parameter int ROWS        = 25,
  parameter int COLS        = 80,
  parameter int MAX_NUMBERS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tte_item_if.sink         item_i,
  tte_result_if.source     result_o
);

  localparam int CELLS = ROWS * COLS;
  localparam int DEPTH = TERMINALS * CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int TW    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int NW    = $clog2(MAX_NUMBERS + 1);
  localparam int IW    = $clog2(MAX_NUMBERS);
  localparam int NUM_W = tte_pkg::NUM_W;

  typedef enum logic [9:0] {
    S_INIT   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_DECODE = 10'b0000000100,
    S_READ   = 10'b0000001000,
    S_FILL   = 10'b0000010000,
    S_SCR_RD = 10'b0000100000,
    S_SCR_WR = 10'b0001000000,
    S_PUT    = 10'b0010000000,
    S_COLOR  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  state_e state_q;

  logic [RW-1:0]    row_q  [TERMINALS];
  logic [CW-1:0]    col_q  [TERMINALS];
  logic             wrap_q [TERMINALS];
  logic [2:0]       fg_q   [TERMINALS];
  logic [2:0]       bg_q   [TERMINALS];
  logic [RW-1:0]    srow_q [TERMINALS];
  logic [CW-1:0]    scol_q [TERMINALS];
  logic [1:0]       pst_q  [TERMINALS];
  logic [NUM_W-1:0] pend_q [TERMINALS];
  logic [NW-1:0]    cnt_q  [TERMINALS];
  logic [NUM_W-1:0] nums_q [TERMINALS][MAX_NUMBERS];

  logic [1:0] op_q;
  logic [1:0] tid_q;
  logic [7:0] byte_q;
  logic [4:0] crow_q;
  logic [6:0] ccol_q;

  logic [AW-1:0]  fill_addr_q;
  logic [AW:0]    fill_end_q;
  tte_pkg::cell_t fill_data_q;
  logic [AW-1:0]  cp_q;
  logic [AW-1:0]  cp_end_q;
  logic           put_q;
  logic [AW-1:0]  put_addr_q;
  tte_pkg::cell_t put_data_q;
  logic [NW-1:0]  mi_q;
  logic [NW-1:0]  mcnt_q;
  tte_pkg::cell_t cell_q;

  logic        out_valid_q;
  logic [15:0] out_cell_q;
  logic [4:0]  out_row_q;
  logic [6:0]  out_col_q;
  logic [2:0]  out_fg_q;
  logic [2:0]  out_bg_q;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  tte_pkg::cell_t mem_wdata;
  logic [AW-1:0]  mem_raddr;
  tte_pkg::cell_t mem_rdata;

  logic [TW-1:0]    tix;
  logic             term_ok;
  logic [AW-1:0]    base;
  logic [AW-1:0]    line;
  logic [AW-1:0]    next_line;
  logic [AW-1:0]    last_line;
  logic [AW-1:0]    rd_addr;
  logic             rd_ok;
  logic [RW-1:0]    row_c;
  logic [CW-1:0]    col_c;
  logic [NUM_W-1:0] pend_c;
  logic [NW-1:0]    cnt_c;
  logic [NW-1:0]    cnt_new;
  logic [NUM_W-1:0] list0;
  logic [NUM_W-1:0] list1;
  logic [15:0]      n16;
  logic [15:0]      v16;
  logic [15:0]      row16;
  logic [15:0]      col16;
  logic [15:0]      stop16;
  logic [16:0]      digit_sum;
  tte_pkg::cell_t   blank;
  tte_pkg::cell_t   put_cell;
  logic [NUM_W-1:0] mval;
  logic             in_fire;
  logic             out_fire;

  always_comb begin
    tix       = TW'(tid_q);
    term_ok   = (32'(tid_q) < TERMINALS);
    base      = AW'(32'(tid_q) * CELLS);
    row_c     = row_q[tix];
    col_c     = col_q[tix];
    pend_c    = pend_q[tix];
    cnt_c     = cnt_q[tix];
    line      = base + AW'(32'(row_c) * COLS);
    next_line = line + AW'(COLS);
    last_line = base + AW'((ROWS - 1) * COLS);
    rd_addr   = base + AW'(32'(crow_q) * COLS) + AW'(ccol_q);
    rd_ok     = (32'(crow_q) < ROWS) && (32'(ccol_q) < COLS);
    cnt_new   = (32'(cnt_c) < MAX_NUMBERS) ? cnt_c + NW'(1) : cnt_c;
    list0     = (cnt_c == '0) ? pend_c : nums_q[tix][0];
    list1     = (cnt_c == NW'(1)) ? pend_c : nums_q[tix][1];
    n16       = (list0 == '0) ? 16'd1 : 16'(list0);
    v16       = ((cnt_c != '0) && (list1 != '0)) ? 16'(list1) : 16'd1;
    row16     = 16'(row_c);
    col16     = 16'(col_c);
    stop16    = {col16[15:3], 3'b000} + 16'd8;
    if (stop16 > 16'(COLS)) begin
      stop16 = 16'(COLS);
    end
    digit_sum = 17'(pend_c) * 17'd10 + 17'(byte_q - tte_pkg::CH_ZERO);
    blank     = tte_pkg::pack_cell(tte_pkg::CH_SPACE, fg_q[tix], bg_q[tix]);
    put_cell  = tte_pkg::pack_cell(byte_q, fg_q[tix], bg_q[tix]);
    mval      = nums_q[tix][IW'(mi_q)];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_addr_q;
    mem_wdata = fill_data_q;
    mem_raddr = rd_addr;
    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tte_pkg::BLANK_RESET;
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_SCR_RD: begin
        mem_raddr = cp_q + AW'(COLS);
      end
      S_SCR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cp_q;
        mem_wdata = mem_rdata;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = put_addr_q;
        mem_wdata = put_data_q;
      end
      default: begin
      end
    endcase
  end

  tte_cell_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_cell_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_fire  = item_i.valid && item_i.ready;
  assign out_fire = out_valid_q && result_o.ready;

  assign item_i.ready        = (state_q == S_IDLE) && !out_valid_q;
  assign result_o.valid      = out_valid_q;
  assign result_o.cell_value = out_cell_q;
  assign result_o.cur_row    = out_row_q;
  assign result_o.cur_col    = out_col_q;
  assign result_o.current_fg = out_fg_q;
  assign result_o.current_bg = out_bg_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_DECODE && term_ok && op_q == tte_pkg::OP_WRITE &&
        pst_q[tix] == tte_pkg::PS_CSI && 32'(cnt_c) < MAX_NUMBERS &&
        !(byte_q >= tte_pkg::CH_ZERO && byte_q <= tte_pkg::CH_NINE)) begin
      nums_q[tix][IW'(cnt_c)] <= pend_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      for (int k = 0; k < TERMINALS; k++) begin
        row_q[k]  <= '0;
        col_q[k]  <= '0;
        wrap_q[k] <= 1'b0;
        fg_q[k]   <= tte_pkg::FG_DEFAULT;
        bg_q[k]   <= tte_pkg::BG_DEFAULT;
        srow_q[k] <= '0;
        scol_q[k] <= '0;
        pst_q[k]  <= tte_pkg::PS_IDLE;
        pend_q[k] <= '0;
        cnt_q[k]  <= '0;
      end
      op_q        <= '0;
      tid_q       <= '0;
      byte_q      <= '0;
      crow_q      <= '0;
      ccol_q      <= '0;
      fill_addr_q <= '0;
      fill_end_q  <= '0;
      fill_data_q <= '0;
      cp_q        <= '0;
      cp_end_q    <= '0;
      put_q       <= 1'b0;
      put_addr_q  <= '0;
      put_data_q  <= '0;
      mi_q        <= '0;
      mcnt_q      <= '0;
      cell_q      <= '0;
      out_valid_q <= 1'b0;
      out_cell_q  <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_fg_q    <= '0;
      out_bg_q    <= '0;
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          fill_addr_q <= fill_addr_q + AW'(1);
          if (32'(fill_addr_q) == DEPTH - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            op_q    <= item_i.opcode;
            tid_q   <= item_i.terminal_id;
            byte_q  <= item_i.byte_in;
            crow_q  <= item_i.cell_row;
            ccol_q  <= item_i.cell_col;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          cell_q  <= '0;
          put_q   <= 1'b0;
          state_q <= S_DONE;
          if (term_ok) begin
            case (op_q)
              tte_pkg::OP_READ: begin
                if (rd_ok) begin
                  state_q <= S_READ;
                end
              end
              tte_pkg::OP_CLEAR: begin
                row_q[tix]  <= '0;
                col_q[tix]  <= '0;
                wrap_q[tix] <= 1'b0;
                fill_addr_q <= base;
                fill_end_q  <= {1'b0, base} + (AW+1)'(CELLS);
                fill_data_q <= tte_pkg::BLANK_RESET;
                state_q     <= S_FILL;
              end
              tte_pkg::OP_WRITE: begin
                if (byte_q == tte_pkg::CH_ESC) begin
                  pst_q[tix]  <= tte_pkg::PS_ESC;
                  pend_q[tix] <= '0;
                  cnt_q[tix]  <= '0;
                end else if (pst_q[tix] == tte_pkg::PS_ESC) begin
                  pst_q[tix] <= (byte_q == tte_pkg::CH_LBRK) ? tte_pkg::PS_CSI
                                                              : tte_pkg::PS_IDLE;
                end else if (pst_q[tix] == tte_pkg::PS_CSI) begin
                  if (byte_q >= tte_pkg::CH_ZERO && byte_q <= tte_pkg::CH_NINE) begin
                    pend_q[tix] <= (digit_sum > 17'(tte_pkg::NUM_LIMIT)) ?
                                   tte_pkg::NUM_LIMIT : NUM_W'(digit_sum);
                  end else if (byte_q == tte_pkg::CH_SEMI) begin
                    pend_q[tix] <= '0;
                    cnt_q[tix]  <= cnt_new;
                  end else begin
                    pend_q[tix] <= '0;
                    cnt_q[tix]  <= cnt_new;
                    pst_q[tix]  <= tte_pkg::PS_IDLE;
                    case (byte_q)
                      tte_pkg::CH_UP: begin
                        row_q[tix]  <= (n16 >= row16) ? '0 : RW'(row16 - n16);
                        wrap_q[tix] <= 1'b0;
                      end
                      tte_pkg::CH_DOWN: begin
                        row_q[tix]  <= (row16 + n16 >= 16'(ROWS)) ? RW'(ROWS - 1)
                                                                   : RW'(row16 + n16);
                        wrap_q[tix] <= 1'b0;
                      end
                      tte_pkg::CH_RIGHT: begin
                        col_q[tix]  <= (col16 + n16 >= 16'(COLS)) ? CW'(COLS - 1)
                                                                   : CW'(col16 + n16);
                        wrap_q[tix] <= 1'b0;
                      end
                      tte_pkg::CH_LEFT: begin
                        col_q[tix]  <= (n16 >= col16) ? '0 : CW'(col16 - n16);
                        wrap_q[tix] <= 1'b0;
                      end
                      tte_pkg::CH_POS_H, tte_pkg::CH_POS_F: begin
                        row_q[tix]  <= (n16 - 16'd1 >= 16'(ROWS)) ? RW'(ROWS - 1)
                                                                   : RW'(n16 - 16'd1);
                        col_q[tix]  <= (v16 - 16'd1 >= 16'(COLS)) ? CW'(COLS - 1)
                                                                   : CW'(v16 - 16'd1);
                        wrap_q[tix] <= 1'b0;
                      end
                      tte_pkg::CH_ED: begin
                        if (list0 == '0) begin
                          wrap_q[tix] <= 1'b0;
                          fill_addr_q <= line + AW'(col_c);
                          fill_end_q  <= {1'b0, next_line};
                          fill_data_q <= blank;
                          state_q     <= S_FILL;
                        end else if (list0 == NUM_W'(2)) begin
                          row_q[tix]  <= '0;
                          col_q[tix]  <= '0;
                          wrap_q[tix] <= 1'b0;
                          fill_addr_q <= base;
                          fill_end_q  <= {1'b0, base} + (AW+1)'(CELLS);
                          fill_data_q <= blank;
                          state_q     <= S_FILL;
                        end
                      end
                      tte_pkg::CH_EL: begin
                        wrap_q[tix] <= 1'b0;
                        fill_addr_q <= line + AW'(col_c);
                        fill_end_q  <= {1'b0, next_line};
                        fill_data_q <= blank;
                        state_q     <= S_FILL;
                      end
                      tte_pkg::CH_SGR: begin
                        mi_q    <= '0;
                        mcnt_q  <= cnt_new;
                        state_q <= S_COLOR;
                      end
                      tte_pkg::CH_SAVE: begin
                        srow_q[tix] <= row_c;
                        scol_q[tix] <= col_c;
                      end
                      tte_pkg::CH_REST: begin
                        row_q[tix]  <= srow_q[tix];
                        col_q[tix]  <= scol_q[tix];
                        wrap_q[tix] <= 1'b0;
                      end
                      default: begin
                      end
                    endcase
                  end
                end else if (byte_q == tte_pkg::CH_LF) begin
                  wrap_q[tix] <= 1'b0;
                  col_q[tix]  <= '0;
                  if (32'(row_c) == ROWS - 1) begin
                    cp_q        <= base;
                    cp_end_q    <= last_line;
                    fill_addr_q <= last_line;
                    fill_end_q  <= {1'b0, base} + (AW+1)'(CELLS);
                    fill_data_q <= blank;
                    state_q     <= S_SCR_RD;
                  end else begin
                    row_q[tix] <= row_c + RW'(1);
                  end
                end else if (byte_q == tte_pkg::CH_CR) begin
                  wrap_q[tix] <= 1'b0;
                  col_q[tix]  <= '0;
                end else if (byte_q == tte_pkg::CH_TAB) begin
                  wrap_q[tix] <= 1'b0;
                  col_q[tix]  <= (stop16 >= 16'(COLS)) ? CW'(COLS - 1) : CW'(stop16);
                  fill_addr_q <= line + AW'(col_c);
                  fill_end_q  <= {1'b0, line} + (AW+1)'(stop16);
                  fill_data_q <= blank;
                  state_q     <= S_FILL;
                end else if (byte_q == tte_pkg::CH_BS) begin
                  wrap_q[tix] <= 1'b0;
                  if (col_c != '0) begin
                    col_q[tix] <= col_c - CW'(1);
                    put_addr_q <= line + AW'(col_c) - AW'(1);
                    put_data_q <= blank;
                    state_q    <= S_PUT;
                  end
                end else if (byte_q >= tte_pkg::CH_SPACE && byte_q <= tte_pkg::CH_DEL) begin
                  put_data_q <= put_cell;
                  if (wrap_q[tix]) begin
                    wrap_q[tix] <= 1'b0;
                    col_q[tix]  <= CW'(1);
                    if (32'(row_c) == ROWS - 1) begin
                      put_q       <= 1'b1;
                      put_addr_q  <= last_line;
                      cp_q        <= base;
                      cp_end_q    <= last_line;
                      fill_addr_q <= last_line;
                      fill_end_q  <= {1'b0, base} + (AW+1)'(CELLS);
                      fill_data_q <= blank;
                      state_q     <= S_SCR_RD;
                    end else begin
                      row_q[tix] <= row_c + RW'(1);
                      put_addr_q <= next_line;
                      state_q    <= S_PUT;
                    end
                  end else begin
                    put_addr_q <= line + AW'(col_c);
                    state_q    <= S_PUT;
                    if (32'(col_c) < COLS - 1) begin
                      col_q[tix] <= col_c + CW'(1);
                    end else begin
                      wrap_q[tix] <= 1'b1;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          cell_q  <= mem_rdata;
          state_q <= S_DONE;
        end
        S_FILL: begin
          fill_addr_q <= fill_addr_q + AW'(1);
          if ({1'b0, fill_addr_q} + (AW+1)'(1) == fill_end_q) begin
            state_q <= put_q ? S_PUT : S_DONE;
          end
        end
        S_SCR_RD: begin
          state_q <= S_SCR_WR;
        end
        S_SCR_WR: begin
          cp_q    <= cp_q + AW'(1);
          state_q <= (cp_q + AW'(1) == cp_end_q) ? S_FILL : S_SCR_RD;
        end
        S_PUT: begin
          put_q   <= 1'b0;
          state_q <= S_DONE;
        end
        S_COLOR: begin
          if (mi_q == mcnt_q) begin
            state_q <= S_DONE;
          end else begin
            mi_q <= mi_q + NW'(1);
            if (mval == tte_pkg::SGR_RESET) begin
              fg_q[tix] <= tte_pkg::FG_DEFAULT;
              bg_q[tix] <= tte_pkg::BG_DEFAULT;
            end else if (mval >= tte_pkg::SGR_FG_LO && mval <= tte_pkg::SGR_FG_HI) begin
              fg_q[tix] <= 3'(mval - tte_pkg::SGR_FG_LO);
            end else if (mval >= tte_pkg::SGR_BG_LO && mval <= tte_pkg::SGR_BG_HI) begin
              bg_q[tix] <= 3'(mval - tte_pkg::SGR_BG_LO);
            end
          end
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          out_cell_q  <= cell_q;
          if (term_ok) begin
            out_row_q <= 5'(row_c);
            out_col_q <= 7'(col_c);
            out_fg_q  <= fg_q[tix];
            out_bg_q  <= bg_q[tix];
          end else begin
            out_row_q <= '0;
            out_col_q <= '0;
            out_fg_q  <= '0;
            out_bg_q  <= '0;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/sv/tte_checker.sv]
// Checker for the text terminal escape engine: predicts each result and compares it.
module tte_checker #(
  parameter int TERMINALS   = 4,
  parameter int ROWS        = 25,
  parameter int COLS        = 80,
  parameter int MAX_NUMBERS = 8
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tte_item_if    item_if,
  tte_result_if  result_if,
  output int     fail_count_o,
  output int     pending_count_o
);

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cur_row;
    logic [6:0]  cur_col;
    logic [2:0]  current_fg;
    logic [2:0]  current_bg;
  } term_result_t;

  tte_pkg::cell_t screen [TERMINALS][ROWS*COLS];
  int          row_pos  [TERMINALS];
  int          col_pos  [TERMINALS];
  bit          wrap_pend[TERMINALS];
  logic [2:0]  fg_col   [TERMINALS];
  logic [2:0]  bg_col   [TERMINALS];
  int          save_row [TERMINALS];
  int          save_col [TERMINALS];
  logic [1:0]  parse_st [TERMINALS];
  int unsigned pend_num [TERMINALS];
  int unsigned num_list [TERMINALS][MAX_NUMBERS];
  int unsigned num_cnt  [TERMINALS];

  term_result_t expected_results[$];
  int fails;

  assign fail_count_o    = fails;
  assign pending_count_o = expected_results.size();

  function automatic tte_pkg::cell_t blank_of(int t);
    return {1'b0, bg_col[t], 1'b0, fg_col[t], tte_pkg::CH_SPACE};
  endfunction

  function automatic void blank_span(int t, int from, int to, tte_pkg::cell_t v);
    for (int i = from; i < to; i++) screen[t][i] = v;
  endfunction

  function automatic void next_line(int t);
    col_pos[t] = 0;
    row_pos[t]++;
    if (row_pos[t] >= ROWS) begin
      for (int i = 0; i < (ROWS-1)*COLS; i++) screen[t][i] = screen[t][i+COLS];
      blank_span(t, (ROWS-1)*COLS, ROWS*COLS, blank_of(t));
      row_pos[t] = ROWS-1;
    end
  endfunction

  function automatic void push_param(int t);
    if (num_cnt[t] < MAX_NUMBERS) begin
      num_list[t][num_cnt[t]] = pend_num[t];
      num_cnt[t]++;
    end
    pend_num[t] = 0;
  endfunction

  function automatic void run_final(int t, logic [7:0] fin);
    int n, line;
    int unsigned v;
    push_param(t);
    n = num_list[t][0] > 0 ? num_list[t][0] : 1;
    line = row_pos[t]*COLS;
    case (fin)
      tte_pkg::CH_UP: begin row_pos[t] -= n; wrap_pend[t] = 0; end
      tte_pkg::CH_DOWN: begin row_pos[t] += n; wrap_pend[t] = 0; end
      tte_pkg::CH_RIGHT: begin col_pos[t] += n; wrap_pend[t] = 0; end
      tte_pkg::CH_LEFT: begin col_pos[t] -= n; wrap_pend[t] = 0; end
      tte_pkg::CH_POS_H, tte_pkg::CH_POS_F: begin
        row_pos[t] = n-1;
        v = num_cnt[t] >= 2 ? num_list[t][1] : 0;
        col_pos[t] = (v > 0 ? v : 1) - 1;
        wrap_pend[t] = 0;
      end
      tte_pkg::CH_ED: begin
        if (num_list[t][0] == 0) begin
          blank_span(t, line+col_pos[t], line+COLS, blank_of(t));
          wrap_pend[t] = 0;
        end else if (num_list[t][0] == 2) begin
          blank_span(t, 0, ROWS*COLS, blank_of(t));
          row_pos[t] = 0; col_pos[t] = 0; wrap_pend[t] = 0;
        end
      end
      tte_pkg::CH_EL: begin
        blank_span(t, line+col_pos[t], line+COLS, blank_of(t));
        wrap_pend[t] = 0;
      end
      tte_pkg::CH_SGR: begin
        for (int i = 0; i < num_cnt[t]; i++) begin
          v = num_list[t][i];
          if (v == tte_pkg::SGR_RESET) begin
            fg_col[t] = tte_pkg::FG_DEFAULT; bg_col[t] = tte_pkg::BG_DEFAULT;
          end else if (v >= tte_pkg::SGR_FG_LO && v <= tte_pkg::SGR_FG_HI) begin
            fg_col[t] = 3'(v - tte_pkg::SGR_FG_LO);
          end else if (v >= tte_pkg::SGR_BG_LO && v <= tte_pkg::SGR_BG_HI) begin
            bg_col[t] = 3'(v - tte_pkg::SGR_BG_LO);
          end
        end
      end
      tte_pkg::CH_SAVE: begin save_row[t] = row_pos[t]; save_col[t] = col_pos[t]; end
      tte_pkg::CH_REST: begin
        row_pos[t] = save_row[t]; col_pos[t] = save_col[t]; wrap_pend[t] = 0;
      end
      default: ;
    endcase
    parse_st[t] = tte_pkg::PS_IDLE;
  endfunction

  function automatic void feed_byte(int t, logic [7:0] b);
    int stop;
    if (b == tte_pkg::CH_ESC) begin
      parse_st[t] = tte_pkg::PS_ESC; pend_num[t] = 0; num_cnt[t] = 0;
    end else if (parse_st[t] == tte_pkg::PS_ESC) begin
      parse_st[t] = b == tte_pkg::CH_LBRK ? tte_pkg::PS_CSI : tte_pkg::PS_IDLE;
    end else if (parse_st[t] == tte_pkg::PS_CSI) begin
      if (b >= tte_pkg::CH_ZERO && b <= tte_pkg::CH_NINE) begin
        pend_num[t] = pend_num[t]*10 + (b - tte_pkg::CH_ZERO);
        if (pend_num[t] > tte_pkg::NUM_LIMIT) pend_num[t] = tte_pkg::NUM_LIMIT;
      end else if (b == tte_pkg::CH_SEMI) begin
        push_param(t);
      end else begin
        run_final(t, b);
      end
    end else if (b == tte_pkg::CH_LF) begin
      wrap_pend[t] = 0; next_line(t);
    end else if (b == tte_pkg::CH_CR) begin
      wrap_pend[t] = 0; col_pos[t] = 0;
    end else if (b == tte_pkg::CH_TAB) begin
      wrap_pend[t] = 0;
      stop = (col_pos[t] & ~7) + 8;
      if (stop > COLS) stop = COLS;
      blank_span(t, row_pos[t]*COLS+col_pos[t], row_pos[t]*COLS+stop, blank_of(t));
      col_pos[t] = stop;
    end else if (b == tte_pkg::CH_BS) begin
      wrap_pend[t] = 0;
      if (col_pos[t] > 0) begin
        col_pos[t]--;
        screen[t][row_pos[t]*COLS+col_pos[t]] = blank_of(t);
      end
    end else if (b >= tte_pkg::CH_SPACE && b <= tte_pkg::CH_DEL) begin
      if (wrap_pend[t]) begin wrap_pend[t] = 0; next_line(t); end
      screen[t][row_pos[t]*COLS+col_pos[t]] = {1'b0, bg_col[t], 1'b0, fg_col[t], b};
      if (col_pos[t] < COLS-1) col_pos[t]++;
      else wrap_pend[t] = 1;
    end
    if (row_pos[t] < 0) row_pos[t] = 0;
    if (row_pos[t] >= ROWS) row_pos[t] = ROWS-1;
    if (col_pos[t] < 0) col_pos[t] = 0;
    if (col_pos[t] >= COLS) col_pos[t] = COLS-1;
  endfunction

  function automatic term_result_t predict_item(logic [1:0] op, logic [1:0] id,
                                               logic [7:0] b, logic [4:0] r, logic [6:0] c);
    term_result_t res;
    int t;
    res = '0;
    t = id;
    if (t >= TERMINALS) return res;
    if (op == tte_pkg::OP_WRITE) feed_byte(t, b);
    else if (op == tte_pkg::OP_READ) begin
      if (r < ROWS && c < COLS) res.cell_value = screen[t][r*COLS+c];
    end else if (op == tte_pkg::OP_CLEAR) begin
      blank_span(t, 0, ROWS*COLS, tte_pkg::BLANK_RESET);
      row_pos[t] = 0; col_pos[t] = 0; wrap_pend[t] = 0;
    end
    res.cur_row = 5'(row_pos[t]);
    res.cur_col = 7'(col_pos[t]);
    res.current_fg = fg_col[t];
    res.current_bg = bg_col[t];
    return res;
  endfunction

  initial begin
    fails = 0;
    for (int t = 0; t < TERMINALS; t++) begin
      blank_span(t, 0, ROWS*COLS, tte_pkg::BLANK_RESET);
      row_pos[t] = 0; col_pos[t] = 0; wrap_pend[t] = 0;
      fg_col[t] = tte_pkg::FG_DEFAULT; bg_col[t] = tte_pkg::BG_DEFAULT;
      save_row[t] = 0; save_col[t] = 0; parse_st[t] = tte_pkg::PS_IDLE;
      pend_num[t] = 0; num_cnt[t] = 0;
      for (int i = 0; i < MAX_NUMBERS; i++) num_list[t][i] = 0;
    end
  end

  always @(posedge clk_i) begin
    term_result_t got, want;
    if (rst_ni) begin
      if (item_if.valid && item_if.ready)
        expected_results.push_back(predict_item(item_if.opcode, item_if.terminal_id,
          item_if.byte_in, item_if.cell_row, item_if.cell_col));
      if (result_if.valid && result_if.ready) begin
        got = {result_if.cell_value, result_if.cur_row, result_if.cur_col,
               result_if.current_fg, result_if.current_bg};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (got.cell_value != want.cell_value) begin
            $display("%0t: cell_value expected %h actual %h", $time,
                     want.cell_value, got.cell_value);
            fails++;
          end
          if (got.cur_row != want.cur_row) begin
            $display("%0t: cur_row expected %0d actual %0d", $time,
                     want.cur_row, got.cur_row);
            fails++;
          end
          if (got.cur_col != want.cur_col) begin
            $display("%0t: cur_col expected %0d actual %0d", $time,
                     want.cur_col, got.cur_col);
            fails++;
          end
          if (got.current_fg != want.current_fg) begin
            $display("%0t: current_fg expected %0d actual %0d", $time,
                     want.current_fg, got.current_fg);
            fails++;
          end
          if (got.current_bg != want.current_bg) begin
            $display("%0t: current_bg expected %0d actual %0d", $time,
                     want.current_bg, got.current_bg);
            fails++;
          end
        end
      end
    end
  end

endmodule

[tb/sv/tb_text_terminal_escape_engine.sv]
// Top of the text terminal escape engine testbench: stimulus, checker and verdict.
module tb_text_terminal_escape_engine;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  bit   recv_busy;

  tte_item_if   item_if ();
  tte_result_if result_if ();

  text_terminal_escape_engine i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  tte_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_if         (item_if),
    .result_if       (result_if),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("tb_text_terminal_escape_engine: errors");
    $finish;
  end

  initial begin
    int mode;
    result_if.ready <= 0;
    @(posedge clk_i iff rst_ni);
    forever begin
      @(posedge clk_i);
      mode = $urandom_range(0, 9);
      if (recv_busy) result_if.ready <= 1;
      else if (mode < 2) result_if.ready <= 0;
      else result_if.ready <= 1;
    end
  end

  task automatic send_item(logic [1:0] op, logic [1:0] id, logic [7:0] b,
                           logic [4:0] r, logic [6:0] c);
    item_if.valid       <= 1;
    item_if.opcode      <= op;
    item_if.terminal_id <= id;
    item_if.byte_in     <= b;
    item_if.cell_row    <= r;
    item_if.cell_col    <= c;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  task automatic put_byte(logic [1:0] id, logic [7:0] b);
    send_item(tte_pkg::OP_WRITE, id, b, 5'($urandom), 7'($urandom));
  endtask

  task automatic put_text(logic [1:0] id, string s);
    for (int i = 0; i < s.len(); i++) put_byte(id, s[i]);
  endtask

  task automatic idle_gap();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      item_if.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] rand_final();
    logic [7:0] finals[12] = '{tte_pkg::CH_UP, tte_pkg::CH_DOWN, tte_pkg::CH_RIGHT,
                               tte_pkg::CH_LEFT, tte_pkg::CH_POS_H, tte_pkg::CH_POS_F,
                               tte_pkg::CH_ED, tte_pkg::CH_EL, tte_pkg::CH_SGR,
                               tte_pkg::CH_SAVE, tte_pkg::CH_REST, 8'h7A};
    return finals[$urandom_range(0, 11)];
  endfunction

  function automatic string rand_param();
    int k;
    k = $urandom_range(0, 5);
    case (k)
      0: return "";
      1: return $sformatf("%0d", $urandom_range(0, 9));
      2: return $sformatf("%0d", $urandom_range(30, 47));
      3: return $sformatf("%0d", $urandom_range(0, 30));
      4: return "2";
      default: return $sformatf("%0d", $urandom_range(0, 99999));
    endcase
  endfunction

  initial begin
    int n;
    logic [1:0] id;
    string seq;
    item_if.valid <= 0;
    item_if.opcode <= tte_pkg::OP_WRITE;
    item_if.terminal_id <= 0;
    item_if.byte_in <= 0;
    item_if.cell_row <= 0;
    item_if.cell_col <= 0;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_item(tte_pkg::OP_READ, 0, 0, 0, 0);
    send_item(tte_pkg::OP_READ, 3, 0, 24, 79);
    send_item(tte_pkg::OP_READ, 1, 0, 31, 127);
    put_text(0, "\033[31;44mA\tB\010");
    put_text(0, "\033[99999;200H~\177Z");
    send_item(tte_pkg::OP_READ, 0, 0, 24, 79);
    put_text(0, "\033[1;1H\033[sx\033[5B\033[u\033[K");
    put_text(1, "\033[3;9f\033[2J\033[0J\033[7Jq\033x\033[1;2;3;4;5;6;7;8;9;0m");
    put_text(1, "\033[12\n\033[3A\033[C\033[D\r\001\200\377\033[25B\n");
    send_item(tte_pkg::OP_NONE, 2, 8'hAA, 0, 0);
    send_item(tte_pkg::OP_CLEAR, 0, 0, 0, 0);

    recv_busy = 0;
    for (int k = 0; k < 110; k++) begin
      id = 2'($urandom);
      n = $urandom_range(0, 19);
      if (k == 55) begin
        item_if.valid <= 0;
        recv_busy = 1;
        @(posedge clk_i);
        while (pending_count != 0) @(posedge clk_i);
        recv_busy = 0;
      end
      if (n < 6) begin
        seq = {"\033[", rand_param()};
        if ($urandom_range(0, 2) != 0) seq = {seq, ";", rand_param()};
        seq = {seq, string'(rand_final())};
        put_text(id, seq);
      end else if (n < 11) begin
        put_byte(id, 8'($urandom_range(32, 127)));
      end else if (n < 13) begin
        put_byte(id, 8'($urandom));
      end else if (n < 15) begin
        put_byte(id, $urandom_range(0, 1) ? tte_pkg::CH_LF :
                     ($urandom_range(0, 1) ? tte_pkg::CH_TAB : tte_pkg::CH_BS));
      end else if (n < 18) begin
        send_item(tte_pkg::OP_READ, id, 8'($urandom), 5'($urandom_range(0, 26)),
                  7'($urandom_range(0, 82)));
      end else if (n < 19) begin
        if ($urandom_range(0, 3) == 0) send_item(tte_pkg::OP_CLEAR, id, 8'($urandom), 0, 0);
        else put_text(id, "\033[24;79H");
      end else begin
        send_item(tte_pkg::OP_NONE, id, 8'($urandom), 5'($urandom), 7'($urandom));
      end
      idle_gap();
    end
    item_if.valid <= 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("tb_text_terminal_escape_engine: clean");
    else $display("tb_text_terminal_escape_engine: errors");
    $finish;
  end

endmodule
